>>> hdl/arw_pkg.sv
// Shared types, constants and helpers for the ARQ receive reorder window.
package arw_pkg;

    localparam int WINDOW_MAX = 64;
    localparam int MAX_FRAGS  = 32;
    localparam int WIN_W      = 7;
    localparam int IDX_W      = 6;
    localparam int DQ_AW      = 7;
    localparam int DQ_DEPTH   = 128;
    localparam int CNT_W      = 6;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOMSG   = 2'd1;
    localparam logic [1:0] ST_END     = 2'd2;
    localparam logic [1:0] ST_TOOSHORT = 2'd3;

    localparam logic OP_ARRIVE  = 1'b0;
    localparam logic OP_CONSUME = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ARR,
        S_MV_CHK,
        S_MV_WR,
        S_SC_RD,
        S_SC_CHK,
        S_EMIT_RD,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic        operation;
        logic [31:0] seq_num;
        logic [4:0]  frags_left;
        logic [10:0] seg_length;
        logic [15:0] payload_tag;
        logic [15:0] buffer_size;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        ack_needed;
        logic [15:0] out_tag;
        logic [10:0] out_length;
        logic [4:0]  out_frags_left;
        logic        last_of_run;
        logic [15:0] message_length;
        logic [6:0]  window_free;
        logic        window_update;
    } res_t;

    function automatic logic [WIN_W-1:0] clamp_window(input logic [WIN_W-1:0] v);
        logic [WIN_W-1:0] r;
        r = v;
        if (v < WIN_W'(MAX_FRAGS)) r = WIN_W'(MAX_FRAGS);
        if (v > WIN_W'(WINDOW_MAX)) r = WIN_W'(WINDOW_MAX);
        return r;
    endfunction

endpackage

>>> hdl/arq_receive_reorder_window.sv
// Top level of the ARQ receive reorder window.
//  channel  | handshake                | payload
//  input    | push / full              | operation ... buffer_size
//  result   | empty / pop              | status ... window_update
//  config   | cfg_valid / cfg_ready    | cfg_data (recv_window)
// Arrival: take, window check, result; when acked, also a check state and a write state per segment moved.
// Consume: take, a read and a check state per scanned segment, then the result; on delivery
//   the scan is followed by the move states, then a read and a result state per delivered result.
// Reset clears all control state at once; no clearing pass.
// A full result queue holds the sequencer in its result cycle; the two-entry command
//   queue then fills and raises full.
module arq_receive_reorder_window
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        operation,
    input  logic [31:0] seq_num,
    input  logic [4:0]  frags_left,
    input  logic [10:0] seg_length,
    input  logic [15:0] payload_tag,
    input  logic [15:0] buffer_size,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  status,
    output logic        ack_needed,
    output logic [15:0] out_tag,
    output logic [10:0] out_length,
    output logic [4:0]  out_frags_left,
    output logic        last_of_run,
    output logic [15:0] message_length,
    output logic [6:0]  window_free,
    output logic        window_update,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data
);

    arw_pkg::cmd_t cmd_in;
    arw_pkg::cmd_t cmd_out;
    arw_pkg::res_t res_in;
    arw_pkg::res_t res_out;
    logic          cmd_valid;
    logic          cmd_pop;
    logic          res_push;
    logic          res_full;

    assign cmd_in.operation   = operation;
    assign cmd_in.seq_num     = seq_num;
    assign cmd_in.frags_left  = frags_left;
    assign cmd_in.seg_length  = seg_length;
    assign cmd_in.payload_tag = payload_tag;
    assign cmd_in.buffer_size = buffer_size;

    arw_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .cmd_in    (cmd_in),
        .full      (full),
        .cmd_valid (cmd_valid),
        .cmd_out   (cmd_out),
        .cmd_pop   (cmd_pop)
    );

    arw_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd_out),
        .cmd_pop   (cmd_pop),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    arw_res_q u_res_q
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_in   (res_in),
        .res_full (res_full),
        .empty    (empty),
        .res_out  (res_out),
        .pop      (pop)
    );

    assign status         = res_out.status;
    assign ack_needed     = res_out.ack_needed;
    assign out_tag        = res_out.out_tag;
    assign out_length     = res_out.out_length;
    assign out_frags_left = res_out.out_frags_left;
    assign last_of_run    = res_out.last_of_run;
    assign message_length = res_out.message_length;
    assign window_free    = res_out.window_free;
    assign window_update  = res_out.window_update;

endmodule

>>> hdl/arw_front.sv
// Front end: accepts items into a two-entry command queue.
module arw_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  arw_pkg::cmd_t  cmd_in,
    output logic           full,
    output logic           cmd_valid,
    output arw_pkg::cmd_t  cmd_out,
    input  logic           cmd_pop
);

    arw_pkg::cmd_t mem_reg [2];
    logic          wptr_reg;
    logic          rptr_reg;
    logic [1:0]    cnt_reg;
    logic          do_push;
    logic          do_pop;

    assign full      = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd_out   = mem_reg[rptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (do_push) wptr_reg <= !wptr_reg;
            if (do_pop) rptr_reg <= !rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

>>> hdl/arw_res_q.sv
// Result queue between the back end and the result ports.
module arw_res_q
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           res_push,
    input  arw_pkg::res_t  res_in,
    output logic           res_full,
    output logic           empty,
    output arw_pkg::res_t  res_out,
    input  logic           pop
);

    arw_pkg::res_t mem_reg [2];
    logic          wptr_reg;
    logic          rptr_reg;
    logic [1:0]    cnt_reg;
    logic          do_push;
    logic          do_pop;

    assign res_full = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign res_out  = mem_reg[rptr_reg];
    assign do_push  = res_push && !res_full;
    assign do_pop   = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= res_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (do_push) wptr_reg <= !wptr_reg;
            if (do_pop) rptr_reg <= !rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

>>> hdl/arw_back.sv
// Back end: reorder store, delivery queue and the sequencer that runs each command.
module arw_back
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    input  arw_pkg::cmd_t                  cmd,
    output logic                           cmd_pop,
    input  logic                           cfg_valid,
    input  logic [arw_pkg::WIN_W-1:0]      cfg_data,
    output logic                           cfg_ready,
    input  logic                           res_full,
    output logic                           res_push,
    output arw_pkg::res_t                  res
);

    arw_pkg::state_t state_reg, state_next;

    logic [arw_pkg::WIN_W-1:0]      win_reg, win_next;
    logic [31:0]                    nexp_reg, nexp_next;
    logic [31:0]                    endseq_reg, endseq_next;
    logic                           endseen_reg, endseen_next;
    logic [arw_pkg::WINDOW_MAX-1:0] valid_reg, valid_next;
    logic [arw_pkg::IDX_W-1:0]      base_reg, base_next;
    logic [arw_pkg::DQ_AW-1:0]      head_reg, head_next;
    logic [arw_pkg::WIN_W-1:0]      count_reg, count_next;
    logic                           tell_reg, tell_next;

    arw_pkg::cmd_t                  item_reg, item_next;
    logic                           ack_reg, ack_next;
    logic [1:0]                     status_reg, status_next;
    logic [15:0]                    msglen_reg, msglen_next;
    logic [arw_pkg::CNT_W-1:0]      scan_reg, scan_next;
    logic [arw_pkg::CNT_W-1:0]      n_reg, n_next;
    logic [arw_pkg::DQ_AW-1:0]      ohead_reg, ohead_next;
    logic [arw_pkg::CNT_W-1:0]      k_reg, k_next;
    logic                           deliver_reg, deliver_next;
    logic                           full_reg, full_next;
    logic                           ret_emit_reg, ret_emit_next;

    logic [31:0] slot_mem [arw_pkg::WINDOW_MAX];
    logic [31:0] dq_mem [arw_pkg::DQ_DEPTH];
    logic [31:0] slot_rd_reg;
    logic [31:0] dq_rd_reg;

    logic                      slot_we;
    logic [arw_pkg::IDX_W-1:0] slot_waddr;
    logic [31:0]               slot_wdata;
    logic                      dq_we;
    logic [arw_pkg::DQ_AW-1:0] dq_waddr;
    logic [arw_pkg::DQ_AW-1:0] dq_raddr;

    logic [31:0]               dwin;
    logic [31:0]               dend;
    logic [31:0]               off;
    logic                      ack_c;
    logic [arw_pkg::IDX_W-1:0] arr_idx;
    logic [15:0]               sum_c;
    logic [arw_pkg::CNT_W-1:0] inc_c;
    logic                      complete_c;
    logic [arw_pkg::WIN_W-1:0] new_w;
    logic [arw_pkg::WIN_W-1:0] wfree_c;
    logic [arw_pkg::WIN_W-1:0] cnt_after;

    assign cfg_ready = (state_reg == arw_pkg::S_IDLE) && !cmd_valid;

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        slot_rd_reg <= slot_mem[base_reg];
    end

    always_ff @(posedge clk)
    begin
        if (dq_we)
        begin
            dq_mem[dq_waddr] <= slot_rd_reg;
        end
        dq_rd_reg <= dq_mem[dq_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= arw_pkg::S_IDLE;
            win_reg      <= arw_pkg::WIN_W'(arw_pkg::MAX_FRAGS);
            nexp_reg     <= '0;
            endseq_reg   <= '0;
            endseen_reg  <= 1'b0;
            valid_reg    <= '0;
            base_reg     <= '0;
            head_reg     <= '0;
            count_reg    <= '0;
            tell_reg     <= 1'b0;
            ret_emit_reg <= 1'b0;
            deliver_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            win_reg      <= win_next;
            nexp_reg     <= nexp_next;
            endseq_reg   <= endseq_next;
            endseen_reg  <= endseen_next;
            valid_reg    <= valid_next;
            base_reg     <= base_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
            tell_reg     <= tell_next;
            ret_emit_reg <= ret_emit_next;
            deliver_reg  <= deliver_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        ack_reg    <= ack_next;
        status_reg <= status_next;
        msglen_reg <= msglen_next;
        scan_reg   <= scan_next;
        n_reg      <= n_next;
        ohead_reg  <= ohead_next;
        k_reg      <= k_next;
        full_reg   <= full_next;
    end

    always_comb
    begin
        dwin       = item_reg.seq_num - (nexp_reg + 32'(win_reg));
        dend       = item_reg.seq_num - endseq_reg;
        off        = item_reg.seq_num - nexp_reg;
        ack_c      = dwin[31] && (!endseen_reg || dend[31]);
        arr_idx    = base_reg + off[arw_pkg::IDX_W-1:0];
        sum_c      = msglen_reg + 16'(dq_rd_reg[15:5]);
        inc_c      = scan_reg + 1'b1;
        complete_c = (dq_rd_reg[4:0] == 5'd0) || (inc_c == arw_pkg::CNT_W'(arw_pkg::MAX_FRAGS));
        new_w      = arw_pkg::clamp_window(cfg_data);
        wfree_c    = (win_reg > count_reg) ? (win_reg - count_reg) : '0;
        cnt_after  = count_reg - arw_pkg::WIN_W'(inc_c);
    end

    always_comb
    begin
        state_next    = state_reg;
        win_next      = win_reg;
        nexp_next     = nexp_reg;
        endseq_next   = endseq_reg;
        endseen_next  = endseen_reg;
        valid_next    = valid_reg;
        base_next     = base_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        tell_next     = tell_reg;
        item_next     = item_reg;
        ack_next      = ack_reg;
        status_next   = status_reg;
        msglen_next   = msglen_reg;
        scan_next     = scan_reg;
        n_next        = n_reg;
        ohead_next    = ohead_reg;
        k_next        = k_reg;
        deliver_next  = deliver_reg;
        full_next     = full_reg;
        ret_emit_next = ret_emit_reg;
        cmd_pop       = 1'b0;
        slot_we       = 1'b0;
        slot_waddr    = arr_idx;
        slot_wdata    = {item_reg.payload_tag, item_reg.seg_length, item_reg.frags_left};
        dq_we         = 1'b0;
        dq_waddr      = head_reg + arw_pkg::DQ_AW'(count_reg);
        dq_raddr      = ohead_reg + arw_pkg::DQ_AW'(k_reg);
        res_push      = 1'b0;
        res           = '0;

        case (state_reg)
            arw_pkg::S_IDLE:
            begin
                if (cfg_valid && cfg_ready)
                begin
                    if (count_reg >= win_reg && count_reg < new_w) tell_next = 1'b1;
                    win_next      = new_w;
                    ret_emit_next = 1'b0;
                    deliver_next  = 1'b0;
                    state_next    = arw_pkg::S_MV_CHK;
                end
                else if (cmd_valid)
                begin
                    cmd_pop      = 1'b1;
                    item_next    = cmd;
                    ack_next     = 1'b0;
                    status_next  = arw_pkg::ST_OK;
                    msglen_next  = '0;
                    scan_next    = '0;
                    n_next       = arw_pkg::CNT_W'(1);
                    k_next       = '0;
                    deliver_next = 1'b0;
                    if (cmd.operation == arw_pkg::OP_ARRIVE)
                    begin
                        state_next = arw_pkg::S_ARR;
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = endseen_reg ? arw_pkg::ST_END : arw_pkg::ST_NOMSG;
                        state_next  = arw_pkg::S_EMIT;
                    end
                    else
                    begin
                        state_next = arw_pkg::S_SC_RD;
                    end
                end
            end

            arw_pkg::S_ARR:
            begin
                ack_next = ack_c;
                if (ack_c)
                begin
                    if (off < 32'(win_reg) && !valid_reg[arr_idx])
                    begin
                        slot_we             = 1'b1;
                        valid_next[arr_idx] = 1'b1;
                    end
                    ret_emit_next = 1'b1;
                    state_next    = arw_pkg::S_MV_CHK;
                end
                else
                begin
                    state_next = arw_pkg::S_EMIT;
                end
            end

            arw_pkg::S_MV_CHK:
            begin
                if (!endseen_reg && count_reg < win_reg && valid_reg[base_reg])
                begin
                    state_next = arw_pkg::S_MV_WR;
                end
                else
                begin
                    if (deliver_reg && full_reg && count_reg < win_reg) tell_next = 1'b1;
                    if (!ret_emit_reg) state_next = arw_pkg::S_IDLE;
                    else if (deliver_reg) state_next = arw_pkg::S_EMIT_RD;
                    else state_next = arw_pkg::S_EMIT;
                end
            end

            arw_pkg::S_MV_WR:
            begin
                dq_we                = 1'b1;
                valid_next[base_reg] = 1'b0;
                if (slot_rd_reg[15:5] == 11'd0)
                begin
                    endseen_next = 1'b1;
                    endseq_next  = nexp_reg + 32'd1;
                end
                count_next = count_reg + 1'b1;
                nexp_next  = nexp_reg + 32'd1;
                base_next  = base_reg + 1'b1;
                state_next = arw_pkg::S_MV_CHK;
            end

            arw_pkg::S_SC_RD:
            begin
                dq_raddr   = head_reg + arw_pkg::DQ_AW'(scan_reg);
                state_next = arw_pkg::S_SC_CHK;
            end

            arw_pkg::S_SC_CHK:
            begin
                msglen_next = sum_c;
                scan_next   = inc_c;
                if (complete_c)
                begin
                    if (sum_c == 16'd0)
                    begin
                        status_next = arw_pkg::ST_END;
                        state_next  = arw_pkg::S_EMIT;
                    end
                    else if (item_reg.buffer_size < sum_c)
                    begin
                        status_next = arw_pkg::ST_TOOSHORT;
                        state_next  = arw_pkg::S_EMIT;
                    end
                    else
                    begin
                        n_next        = inc_c;
                        full_next     = (count_reg >= win_reg);
                        ohead_next    = head_reg;
                        head_next     = head_reg + arw_pkg::DQ_AW'(inc_c);
                        count_next    = cnt_after;
                        deliver_next  = 1'b1;
                        ret_emit_next = 1'b1;
                        state_next    = arw_pkg::S_MV_CHK;
                    end
                end
                else if (arw_pkg::WIN_W'(inc_c) == count_reg)
                begin
                    status_next = arw_pkg::ST_NOMSG;
                    msglen_next = '0;
                    state_next  = arw_pkg::S_EMIT;
                end
                else
                begin
                    state_next = arw_pkg::S_SC_RD;
                end
            end

            arw_pkg::S_EMIT_RD:
            begin
                state_next = arw_pkg::S_EMIT;
            end

            arw_pkg::S_EMIT:
            begin
                res.status         = status_reg;
                res.ack_needed     = ack_reg;
                res.last_of_run    = ((k_reg + 1'b1) == n_reg);
                res.message_length = msglen_reg;
                res.window_free    = wfree_c;
                res.window_update  = tell_reg;
                if (deliver_reg)
                begin
                    res.out_tag        = dq_rd_reg[31:16];
                    res.out_length     = dq_rd_reg[15:5];
                    res.out_frags_left = dq_rd_reg[4:0];
                end
                if (!res_full)
                begin
                    res_push = 1'b1;
                    k_next   = k_reg + 1'b1;
                    if (res.last_of_run)
                    begin
                        tell_next  = 1'b0;
                        state_next = arw_pkg::S_IDLE;
                    end
                    else
                    begin
                        state_next = arw_pkg::S_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = arw_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> bench/arw_checker.sv
// Checker for the ARQ receive reorder window: predicts result transactions and compares them.
`timescale 1ns / 1ps
module arw_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic        operation,
    input  logic [31:0] seq_num,
    input  logic [4:0]  frags_left,
    input  logic [10:0] seg_length,
    input  logic [15:0] payload_tag,
    input  logic [15:0] buffer_size,
    input  logic        empty,
    input  logic        pop,
    input  logic [1:0]  status,
    input  logic        ack_needed,
    input  logic [15:0] out_tag,
    input  logic [10:0] out_length,
    input  logic [4:0]  out_frags_left,
    input  logic        last_of_run,
    input  logic [15:0] message_length,
    input  logic [6:0]  window_free,
    input  logic        window_update,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [6:0]  cfg_data,
    output int          fail_count,
    output int          pending,
    output logic [31:0] next_seq,
    output int          qdepth,
    output int          n_arrivals,
    output int          n_consumes,
    output int          n_results,
    output int          n_updates
);

    localparam int EXP_DEPTH = 1024;

    int            win;
    logic [31:0]   nexp;
    logic [31:0]   end_at;
    logic          end_seen;
    logic          st_valid [arw_pkg::WINDOW_MAX];
    logic [15:0]   st_tag   [arw_pkg::WINDOW_MAX];
    logic [10:0]   st_len   [arw_pkg::WINDOW_MAX];
    logic [4:0]    st_frg   [arw_pkg::WINDOW_MAX];
    logic [15:0]   dq_tag   [arw_pkg::WINDOW_MAX];
    logic [10:0]   dq_len   [arw_pkg::WINDOW_MAX];
    logic [4:0]    dq_frg   [arw_pkg::WINDOW_MAX];
    int            qhead;
    int            qcount;
    int            rbase;
    logic          tell;
    arw_pkg::res_t exp_mem [EXP_DEPTH];
    int            exp_wr;
    int            exp_rd;
    int            fails;
    int            arr_cnt;
    int            con_cnt;
    int            res_cnt;
    int            upd_cnt;

    function automatic int clamp_win(input int v);
        if (v < arw_pkg::MAX_FRAGS) return arw_pkg::MAX_FRAGS;
        if (v > arw_pkg::WINDOW_MAX) return arw_pkg::WINDOW_MAX;
        return v;
    endfunction

    function automatic void move_in_order();
        int idx;
        int dst;
        while (!end_seen && qcount < win)
        begin
            idx = rbase % arw_pkg::WINDOW_MAX;
            if (!st_valid[idx]) break;
            st_valid[idx] = 1'b0;
            if (st_len[idx] == 0)
            begin
                end_seen = 1'b1;
                end_at = nexp + 32'd1;
            end
            dst = (qhead + qcount) % arw_pkg::WINDOW_MAX;
            dq_tag[dst] = st_tag[idx];
            dq_len[dst] = st_len[idx];
            dq_frg[dst] = st_frg[idx];
            qcount++;
            nexp++;
            rbase = (idx + 1) % arw_pkg::WINDOW_MAX;
        end
    endfunction

    function automatic void predict_item(input arw_pkg::cmd_t c);
        logic [31:0]   dwin;
        logic [31:0]   dend;
        logic [31:0]   off;
        logic [1:0]    st;
        logic          ack;
        logic          deliver;
        logic          complete;
        logic          was_full;
        int            msglen;
        int            i;
        int            n;
        int            idx;
        int            wfree;
        arw_pkg::res_t r;
        arw_pkg::res_t outs [arw_pkg::MAX_FRAGS];
        st = arw_pkg::ST_OK;
        ack = 1'b0;
        deliver = 1'b0;
        complete = 1'b0;
        msglen = 0;
        i = 0;
        n = 1;
        if (c.operation == arw_pkg::OP_ARRIVE)
        begin
            arr_cnt++;
            dwin = c.seq_num - (nexp + 32'(win));
            dend = c.seq_num - end_at;
            if (dwin[31] && (!end_seen || dend[31]))
            begin
                ack = 1'b1;
                off = c.seq_num - nexp;
                if (off < 32'(win))
                begin
                    idx = (rbase + int'(off)) % arw_pkg::WINDOW_MAX;
                    if (!st_valid[idx])
                    begin
                        st_valid[idx] = 1'b1;
                        st_tag[idx] = c.payload_tag;
                        st_len[idx] = c.seg_length;
                        st_frg[idx] = c.frags_left;
                    end
                end
                move_in_order();
            end
        end
        else
        begin
            con_cnt++;
            if (qcount == 0)
            begin
                st = end_seen ? arw_pkg::ST_END : arw_pkg::ST_NOMSG;
            end
            else
            begin
                while (i < qcount && i < arw_pkg::MAX_FRAGS)
                begin
                    idx = (qhead + i) % arw_pkg::WINDOW_MAX;
                    msglen += dq_len[idx];
                    i++;
                    if (dq_frg[idx] == 0)
                    begin
                        complete = 1'b1;
                        break;
                    end
                end
                if (!complete && i == arw_pkg::MAX_FRAGS) complete = 1'b1;
                if (!complete)
                begin
                    st = arw_pkg::ST_NOMSG;
                    msglen = 0;
                end
                else if (msglen == 0) st = arw_pkg::ST_END;
                else if (int'(c.buffer_size) < msglen) st = arw_pkg::ST_TOOSHORT;
                else
                begin
                    was_full = qcount >= win;
                    n = i;
                    for (int k = 0; k < n; k++)
                    begin
                        idx = (qhead + k) % arw_pkg::WINDOW_MAX;
                        r = '0;
                        r.out_tag = dq_tag[idx];
                        r.out_length = dq_len[idx];
                        r.out_frags_left = dq_frg[idx];
                        outs[k] = r;
                    end
                    qhead = (qhead + n) % arw_pkg::WINDOW_MAX;
                    qcount -= n;
                    move_in_order();
                    if (was_full && qcount < win) tell = 1'b1;
                    deliver = 1'b1;
                end
            end
        end
        wfree = win > qcount ? win - qcount : 0;
        for (int k = 0; k < n; k++)
        begin
            r = deliver ? outs[k] : arw_pkg::res_t'('0);
            r.status = st;
            r.ack_needed = ack;
            r.last_of_run = (k == n - 1);
            r.message_length = msglen[15:0];
            r.window_free = wfree[6:0];
            r.window_update = tell;
            exp_mem[exp_wr % EXP_DEPTH] = r;
            exp_wr++;
        end
        if (tell) upd_cnt++;
        tell = 1'b0;
    endfunction

    task automatic check_result();
        arw_pkg::res_t e;
        if (exp_wr == exp_rd)
        begin
            $error("result transaction with nothing expected");
            fails++;
            return;
        end
        e = exp_mem[exp_rd % EXP_DEPTH];
        exp_rd++;
        res_cnt++;
        if (status !== e.status)
        begin
            $error("status exp %0d got %0d", e.status, status);
            fails++;
        end
        if (ack_needed !== e.ack_needed)
        begin
            $error("ack_needed exp %0d got %0d", e.ack_needed, ack_needed);
            fails++;
        end
        if (out_tag !== e.out_tag)
        begin
            $error("out_tag exp %0h got %0h", e.out_tag, out_tag);
            fails++;
        end
        if (out_length !== e.out_length)
        begin
            $error("out_length exp %0d got %0d", e.out_length, out_length);
            fails++;
        end
        if (out_frags_left !== e.out_frags_left)
        begin
            $error("out_frags_left exp %0d got %0d", e.out_frags_left, out_frags_left);
            fails++;
        end
        if (last_of_run !== e.last_of_run)
        begin
            $error("last_of_run exp %0d got %0d", e.last_of_run, last_of_run);
            fails++;
        end
        if (message_length !== e.message_length)
        begin
            $error("message_length exp %0d got %0d", e.message_length, message_length);
            fails++;
        end
        if (window_free !== e.window_free)
        begin
            $error("window_free exp %0d got %0d", e.window_free, window_free);
            fails++;
        end
        if (window_update !== e.window_update)
        begin
            $error("window_update exp %0d got %0d", e.window_update, window_update);
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win = arw_pkg::MAX_FRAGS;
            nexp = '0;
            end_at = '0;
            end_seen = 1'b0;
            for (int k = 0; k < arw_pkg::WINDOW_MAX; k++) st_valid[k] = 1'b0;
            qhead = 0;
            qcount = 0;
            rbase = 0;
            tell = 1'b0;
            exp_wr = 0;
            exp_rd = 0;
            fails = 0;
            arr_cnt = 0;
            con_cnt = 0;
            res_cnt = 0;
            upd_cnt = 0;
        end
        else
        begin
            if (pop && !empty) check_result();
            if (cfg_valid && cfg_ready)
            begin
                if (qcount >= win && qcount < clamp_win(int'(cfg_data))) tell = 1'b1;
                win = clamp_win(int'(cfg_data));
                move_in_order();
            end
            if (push && !full)
                predict_item('{operation, seq_num, frags_left, seg_length,
                               payload_tag, buffer_size});
        end
        fail_count <= fails;
        pending    <= exp_wr - exp_rd;
        next_seq   <= nexp;
        qdepth     <= qcount;
        n_arrivals <= arr_cnt;
        n_consumes <= con_cnt;
        n_results  <= res_cnt;
        n_updates  <= upd_cnt;
    end

endmodule

>>> bench/arq_receive_reorder_window_test.sv
// Testbench top for the ARQ receive reorder window: stimulus, idling and verdict.
`timescale 1ns / 1ps
module arq_receive_reorder_window_test;

    localparam int LIMIT = 600000;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic        operation;
    logic [31:0] seq_num;
    logic [4:0]  frags_left;
    logic [10:0] seg_length;
    logic [15:0] payload_tag;
    logic [15:0] buffer_size;
    logic        empty;
    logic        pop;
    logic [1:0]  status;
    logic        ack_needed;
    logic [15:0] out_tag;
    logic [10:0] out_length;
    logic [4:0]  out_frags_left;
    logic        last_of_run;
    logic [15:0] message_length;
    logic [6:0]  window_free;
    logic        window_update;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [6:0]  cfg_data;

    int          fail_count;
    int          pending;
    logic [31:0] next_seq;
    int          qdepth;
    int          n_arrivals;
    int          n_consumes;
    int          n_results;
    int          n_updates;

    int          cycles;
    logic        calm;
    logic        hold_req;
    logic        hold_done;
    logic [31:0] gen_seq;

    arq_receive_reorder_window DUT (.*);
    arw_checker checker_i (.*);

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        pop       = 1'b0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                pop <= 1'b0;
                repeat (400) @(posedge clk);
                hold_done = 1'b1;
            end
            else
                pop <= calm || $urandom_range(99) >= 6;
        end
    end

    task automatic send_item(input logic op, input logic [31:0] s, input logic [4:0] f,
                             input logic [10:0] l, input logic [15:0] t, input logic [15:0] b);
        if (!calm && $urandom_range(99) < 6)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        push        <= 1'b1;
        operation   <= op;
        seq_num     <= s;
        frags_left  <= f;
        seg_length  <= l;
        payload_tag <= t;
        buffer_size <= b;
        @(posedge clk);
        while (full) @(posedge clk);
    endtask

    task automatic arrive(input logic [31:0] s, input logic [4:0] f, input logic [10:0] l);
        send_item(arw_pkg::OP_ARRIVE, s, f, l, 16'($urandom), 16'($urandom));
    endtask

    task automatic consume(input logic [15:0] b);
        send_item(arw_pkg::OP_CONSUME, 32'($urandom), 5'($urandom), 11'($urandom),
                  16'($urandom), b);
    endtask

    function automatic logic [15:0] rand_buf();
        int p;
        p = $urandom_range(99);
        if (p < 8) return 16'd0;
        if (p < 20) return 16'($urandom_range(0, 4000));
        return 16'hFFFF;
    endfunction

    function automatic logic [10:0] rand_len();
        return ($urandom_range(3) == 0) ? 11'($urandom_range(1, 2047))
                                        : 11'($urandom_range(1, 64));
    endfunction

    // one message of nf segments in order or shuffled, with some duplicates and noise
    task automatic send_message(input int nf);
        logic [31:0] sq [8];
        logic [4:0]  fr [8];
        logic [31:0] ts;
        logic [4:0]  tf;
        int          j;
        int          a;
        if (gen_seq - next_seq > 32'd24) gen_seq = next_seq;
        for (int k = 0; k < nf; k++)
        begin
            sq[k] = gen_seq + 32'(k);
            fr[k] = 5'(nf - 1 - k);
        end
        if ($urandom_range(1) == 1)
            for (int k = 0; k < nf; k++)
            begin
                j = $urandom_range(nf - 1);
                ts = sq[k];
                sq[k] = sq[j];
                sq[j] = ts;
                tf = fr[k];
                fr[k] = fr[j];
                fr[j] = tf;
            end
        for (int k = 0; k < nf; k++)
        begin
            arrive(sq[k], fr[k], rand_len());
            if ($urandom_range(99) < 8)
            begin
                a = $urandom_range(nf - 1);
                arrive(sq[a], 5'($urandom), rand_len());
            end
            if ($urandom_range(99) < 4) arrive(32'($urandom), 5'($urandom), 11'($urandom));
        end
        gen_seq += 32'(nf);
    endtask

    task automatic random_traffic(input int count);
        int start;
        start = n_arrivals + n_consumes;
        while (n_arrivals + n_consumes - start < count)
        begin
            send_message(($urandom_range(9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4));
            if ($urandom_range(99) < 90) consume(rand_buf());
            if ($urandom_range(99) < 20) consume(rand_buf());
        end
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_window(input logic [6:0] v);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        for (int k = 0; k < 40 && qdepth > 0; k++) consume(16'hFFFF);
    endtask

    initial
    begin
        calm        = 1'b1;
        hold_req    = 1'b0;
        gen_seq     = '0;
        rst_n       = 1'b0;
        push        = 1'b0;
        operation   = arw_pkg::OP_ARRIVE;
        seq_num     = '0;
        frags_left  = '0;
        seg_length  = '0;
        payload_tag = '0;
        buffer_size = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_window(7'd0);
        consume(16'hFFFF);
        send_item(arw_pkg::OP_ARRIVE, 32'hFFFF_FFFF, 5'd31, 11'd2047, 16'hFFFF, 16'hFFFF);
        send_item(arw_pkg::OP_ARRIVE, 32'h8000_0000, 5'd0, 11'd5, 16'h0000, 16'h0000);
        send_item(arw_pkg::OP_ARRIVE, 32'd1, 5'd0, 11'd1, 16'h0000, 16'h0000);
        send_item(arw_pkg::OP_ARRIVE, 32'd0, 5'd1, 11'd2047, 16'hFFFF, 16'hFFFF);
        consume(16'd0);
        consume(16'd2047);
        consume(16'hFFFF);
        arrive(32'd2, 5'd1, 11'd7);
        consume(16'hFFFF);
        arrive(32'd3, 5'd0, 11'd9);
        consume(16'd16);
        arrive(32'd5, 5'd0, 11'd3);
        send_item(arw_pkg::OP_ARRIVE, 32'd5, 5'd0, 11'd4, 16'h1234, 16'h0);
        arrive(32'd4, 5'd0, 11'd2);
        arrive(32'd40, 5'd0, 11'd2);
        consume(16'hFFFF);
        consume(16'hFFFF);
        gen_seq = 32'd6;

        random_traffic(50);
        calm = 1'b0;
        random_traffic(60);

        // receiver holds off while single-segment messages fill the delivery queue
        wait_idle();
        drain();
        hold_req = 1'b1;
        for (int k = 0; k < 40; k++)
        begin
            arrive(gen_seq, 5'd0, rand_len());
            gen_seq++;
        end
        write_window(7'd127);
        consume(16'hFFFF);
        consume(16'hFFFF);
        drain();

        // head run longer than one message can hold
        wait_idle();
        if (gen_seq - next_seq > 32'd24) gen_seq = next_seq;
        for (int k = 0; k < 32; k++) arrive(gen_seq + 32'(k), 5'($urandom_range(1, 31)), 11'd20);
        arrive(gen_seq + 32'd32, 5'd0, 11'd5);
        gen_seq += 32'd33;
        consume(16'd100);
        consume(16'hFFFF);
        consume(16'hFFFF);
        random_traffic(60);

        write_window(7'd64);
        random_traffic(40);
        write_window(7'd45);
        random_traffic(40);
        write_window(7'd32);
        random_traffic(20);

        // end of stream
        wait_idle();
        drain();
        if (gen_seq - next_seq > 32'd24) gen_seq = next_seq;
        arrive(gen_seq + 32'd1, 5'd0, 11'd8);
        arrive(gen_seq, 5'd0, 11'd0);
        arrive(gen_seq + 32'd1, 5'd0, 11'd8);
        arrive(gen_seq - 32'd1, 5'd0, 11'd8);
        for (int k = 0; k < 3; k++) consume(16'hFFFF);
        consume(16'hFFFF);

        wait_idle();
        repeat (50) @(posedge clk);
        $display("covered %0d arrivals, %0d consumes, %0d results, %0d window updates",
                 n_arrivals, n_consumes, n_results, n_updates);
        $display("windows 32, 45 and 64, receiver stall, reorder, duplicates and end of stream");
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
